### hw/rtl/gmr_pkg.sv
// Package for the monotone grid reachability core.
// Holds field widths, stream packing offsets, codes, FSM and command types and the row spread function.
// Used by the core top, gmr_ctrl and gmr_datapath; depends on nothing.
`default_nettype none

package gmr_pkg;

  // Field and register widths
  localparam int ROW_W      = 6;
  localparam int GRID_W     = 64;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;
  // Rows reachable through a 6-bit row index
  localparam int ADDR_SPAN  = 64;

  // Stream payload widths (whole bytes)
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 8;

  // Input tdata field offsets, lowest bit up
  localparam int OFS_ROW_INDEX = 0;
  localparam int OFS_ROW_BITS  = 6;
  localparam int OFS_SRC_ROW   = 70;
  localparam int OFS_SRC_COL   = 76;
  localparam int OFS_DST_ROW   = 82;
  localparam int OFS_DST_COL   = 88;

  // Request kinds carried on in_tuser
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } gmr_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic finish;
  } gmr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic reject;
    logic last;
    logic out_free;
  } gmr_status_t;

  // Widen each reach bit to the right through its run of free cells.
  // The carry of freem + seed runs through a free run and stops past it.
  function automatic logic [GRID_W-1:0] spread_right(input logic [GRID_W-1:0] reach,
                                                     input logic [GRID_W-1:0] freem);
    logic [GRID_W-1:0] seed;
    logic [GRID_W-1:0] sum;
    seed = reach & freem;
    sum  = freem + seed;
    return freem & (~sum | seed);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/grid_monotone_reachability_core.sv
// Top level of the monotone grid reachability core.
// Joins the controller FSM (gmr_ctrl) and the datapath (gmr_datapath); uses gmr_pkg.
//
// Channel  Dir   Handshake            Payload
// in_      in    tvalid/tready        tuser: mode; tdata: row_index, row_bits, src/dst cells
// out_     out   tvalid/tready        tdata: reachable
// cfg_     in    we (no wait)         index, wdata: rows_in_use, cols_in_use
//
// A load is handled in the idle state. A query is accepted, sweeps one grid row at a
// time from source to target and loads the output register; a query with the target
// above or left of the source goes from accept straight to the output register. The
// grid RAM's one read per cycle feeds the 64-bit carry spread of each row.
// Synchronous active-low reset clears the row valid bits, so every cell reads blocked.
// A result waits in the output register while the next request is accepted; a query
// that finishes while it still waits holds in its last state.
`default_nettype none

module grid_monotone_reachability_core #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [gmr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gmr_pkg::CFG_W-1:0]       cfg_wdata,
  // Requests
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // tdata, lowest bit up: row_index[5:0], row_bits[69:6], src_row[75:70],
  //   src_col[81:76], dst_row[87:82], dst_col[93:88], zero pad[95:94]
  input  wire logic [gmr_pkg::IN_DATA_W-1:0]   in_tdata,
  // tuser: mode[0]
  input  wire logic                            in_tuser,
  // Results
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // tdata, lowest bit up: reachable[0], zero pad[7:1]
  output logic      [gmr_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import gmr_pkg::*;

  gmr_cmd_t    cmd;
  gmr_status_t status;

  gmr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  gmr_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

endmodule

`default_nettype wire

### hw/rtl/gmr_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module gmr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hw/rtl/gmr_ctrl.sv
// Controller FSM of the grid reachability core: accepts requests, sequences the
// row sweep and hands the answer to the output register. Depends on gmr_pkg.
`default_nettype none

module gmr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  input  wire logic                in_tuser,
  output logic                     in_tready,
  input  wire gmr_pkg::gmr_status_t status,
  output gmr_pkg::gmr_cmd_t        cmd
);
  import gmr_pkg::*;

  gmr_state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == MODE_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = status.reject ? ST_FINISH : ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        cmd.step = 1'b1;
        if (status.last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/gmr_datapath.sv
// Datapath of the grid reachability core: configuration registers, grid RAM
// with row valid bits, row sweep register and output register.
// Depends on gmr_pkg and gmr_ram.
`default_nettype none

module gmr_datapath #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [gmr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gmr_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic [gmr_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire gmr_pkg::gmr_cmd_t               cmd,
  output gmr_pkg::gmr_status_t                 status,
  output logic      [gmr_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready
);
  import gmr_pkg::*;

  localparam int DEPTH = (ROWS < ADDR_SPAN) ? ROWS : ADDR_SPAN;
  localparam int AW    = $clog2(DEPTH);

  // Request fields
  logic [ROW_W-1:0]  f_row_index;
  logic [GRID_W-1:0] f_row_bits;
  logic [ROW_W-1:0]  f_src_row, f_src_col, f_dst_row, f_dst_col;

  assign f_row_index = in_tdata[OFS_ROW_INDEX +: ROW_W];
  assign f_row_bits  = in_tdata[OFS_ROW_BITS  +: GRID_W];
  assign f_src_row   = in_tdata[OFS_SRC_ROW   +: ROW_W];
  assign f_src_col   = in_tdata[OFS_SRC_COL   +: ROW_W];
  assign f_dst_row   = in_tdata[OFS_DST_ROW   +: ROW_W];
  assign f_dst_col   = in_tdata[OFS_DST_COL   +: ROW_W];

  logic [CFG_W-1:0]  rows_use_r, cols_use_r;
  logic [DEPTH-1:0]  valid_r;
  logic [GRID_W-1:0] col_mask;
  logic [ROW_W-1:0]  cur_row_r, dr_r, dc_r;
  logic [GRID_W-1:0] reach_r;
  logic              rd_ok_r;
  logic              out_valid_r, out_data_r;

  logic [ROW_W-1:0]  rd_row;
  logic              rd_ok;
  logic              wr_en;
  logic [GRID_W-1:0] ram_rdata;
  logic [GRID_W-1:0] free_cells;

  // Columns in use, clipped to COLS
  always_comb begin
    for (int j = 0; j < GRID_W; j++) begin
      col_mask[j] = (j < int'(cols_use_r)) && (j < COLS);
    end
  end

  // Pick the row to fetch: source row on start, else the one after the current
  assign rd_row = cmd.start ? f_src_row : ROW_W'(cur_row_r + 1'b1);
  assign rd_ok  = ({1'b0, rd_row} < rows_use_r) && (int'(rd_row) < ROWS)
                  && valid_r[rd_row[AW-1:0]];

  // Drop loads beyond the grid
  assign wr_en = cmd.load && (int'(f_row_index) < ROWS);

  gmr_ram #(
    .WIDTH (GRID_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (wr_en),
    .waddr (f_row_index[AW-1:0]),
    .wdata (f_row_bits),
    .raddr (rd_row[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Free cells of the row arriving from the RAM
  assign free_cells = ram_rdata & col_mask & {GRID_W{rd_ok_r}};

  // Configuration, row valid bits and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_use_r  <= CFG_W'(ADDR_SPAN);
      cols_use_r  <= CFG_W'(ADDR_SPAN);
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROWS_IN_USE: rows_use_r <= cfg_wdata;
          CFG_COLS_IN_USE: cols_use_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (wr_en) begin
        valid_r[f_row_index[AW-1:0]] <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sweep: seed the source column, then spread and carry down row by row
  always_ff @(posedge clk) begin
    rd_ok_r <= rd_ok;
    if (cmd.start) begin
      cur_row_r <= f_src_row;
      dr_r      <= f_dst_row;
      dc_r      <= f_dst_col;
      reach_r   <= status.reject ? '0 : ({{(GRID_W-1){1'b0}}, 1'b1} << f_src_col);
    end else if (cmd.step) begin
      cur_row_r <= ROW_W'(cur_row_r + 1'b1);
      reach_r   <= spread_right(reach_r, free_cells);
    end
    if (cmd.finish) begin
      out_data_r <= reach_r[dc_r];
    end
  end

  assign status.reject   = (f_dst_row < f_src_row) || (f_dst_col < f_src_col);
  assign status.last     = (cur_row_r == dr_r);
  assign status.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_data_r};

  // A pending answer is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_tready))
    else $error("answer loaded over a pending result");

  // The sweep never runs past the target row
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (cur_row_r <= dr_r))
    else $error("sweep passed the target row");

  // Reach stays inside the columns in use
  a_reach_cols: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> ((reach_r & ~$past(col_mask)) == '0))
    else $error("reach set outside columns in use");

endmodule

`default_nettype wire

### sim/gmr_reach_checker.sv
// Checker for the monotone grid reachability core: watches the request, result and
// configuration ports, predicts each query answer and compares it with the block.
// Depends on gmr_pkg for widths, field offsets, request kinds and register indexes.
`timescale 1ns / 100ps

module gmr_reach_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [gmr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gmr_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  // tdata, lowest bit up: row_index, row_bits, src_row, src_col, dst_row, dst_col, pad
  input  logic [gmr_pkg::IN_DATA_W-1:0]      in_tdata,
  // tuser: mode
  input  logic                               in_tuser,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata, lowest bit up: reachable, pad
  input  logic [gmr_pkg::OUT_DATA_W-1:0]     out_tdata,
  output int                                 mismatch_count,
  output int                                 answers_owed
);
  import gmr_pkg::*;

  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;

  logic [GRID_W-1:0] grid_copy [GRID_ROWS];
  logic [CFG_W-1:0]  rows_setting;
  logic [CFG_W-1:0]  cols_setting;
  logic              reach_answers [$];

  // Free cells of one row as the block sees them: rows and columns past the
  // settings read as blocked, stored bits are kept
  function automatic logic [GRID_W-1:0] usable_cells(input int unsigned r);
    int unsigned       nrows;
    int unsigned       ncols;
    logic [GRID_W-1:0] colmask;
    nrows = (rows_setting > GRID_ROWS) ? GRID_ROWS : rows_setting;
    ncols = (cols_setting > GRID_COLS) ? GRID_COLS : cols_setting;
    if (r >= nrows) return '0;
    colmask = (ncols >= GRID_W) ? '1 : ((64'd1 << ncols) - 64'd1);
    return grid_copy[r] & colmask;
  endfunction

  // Extend each reached column rightward through the run of free cells it sits in
  function automatic logic [GRID_W-1:0] widen_reach(input logic [GRID_W-1:0] seed,
                                                    input logic [GRID_W-1:0] open);
    logic [GRID_W-1:0] spread;
    logic              carry;
    carry = 1'b0;
    for (int j = 0; j < GRID_W; j++) begin
      spread[j] = open[j] & (seed[j] | carry);
      carry     = spread[j];
    end
    return spread;
  endfunction

  // Sweep from the source row down to the target row, one row at a time
  function automatic logic predict_reachable(input logic [ROW_W-1:0] sr,
                                             input logic [ROW_W-1:0] sc,
                                             input logic [ROW_W-1:0] dr,
                                             input logic [ROW_W-1:0] dc);
    logic [GRID_W-1:0] reach;
    if (dr < sr || dc < sc) return 1'b0;
    reach = 64'd1 << sc;
    for (int r = sr; r <= dr; r++) reach = widen_reach(reach, usable_cells(r));
    return reach[dc];
  endfunction

  always @(posedge clk) begin : watch
    logic             want;
    logic [ROW_W-1:0] row_sel;
    if (!rst_n) begin
      foreach (grid_copy[i]) grid_copy[i] = '0;
      rows_setting   = 7'd64;
      cols_setting   = 7'd64;
      reach_answers.delete();
      mismatch_count = 0;
    end else begin
      // Track register writes
      if (cfg_we) begin
        if (cfg_index == CFG_ROWS_IN_USE) rows_setting = cfg_wdata;
        else if (cfg_index == CFG_COLS_IN_USE) cols_setting = cfg_wdata;
      end
      // Compare each result with the oldest outstanding answer
      if (out_tvalid && out_tready) begin
        if (reach_answers.size() == 0) begin
          $error("reachable: no query outstanding, actual %0d", out_tdata[0]);
          mismatch_count++;
        end else begin
          want = reach_answers.pop_front();
          if (out_tdata[0] !== want) begin
            $error("reachable: expected %0d, actual %0d", want, out_tdata[0]);
            mismatch_count++;
          end
          if (out_tdata[OUT_DATA_W-1:1] !== '0) begin
            $error("pad: expected 0, actual %0h", out_tdata[OUT_DATA_W-1:1]);
            mismatch_count++;
          end
        end
      end
      // Apply loads and queue the answer of each query at the tail
      if (in_tvalid && in_tready) begin
        if (in_tuser == MODE_LOAD) begin
          row_sel = in_tdata[OFS_ROW_INDEX +: ROW_W];
          grid_copy[row_sel] = in_tdata[OFS_ROW_BITS +: GRID_W];
        end else begin
          reach_answers.insert(reach_answers.size(),
                               predict_reachable(in_tdata[OFS_SRC_ROW +: ROW_W],
                                                 in_tdata[OFS_SRC_COL +: ROW_W],
                                                 in_tdata[OFS_DST_ROW +: ROW_W],
                                                 in_tdata[OFS_DST_COL +: ROW_W]));
        end
      end
    end
    answers_owed = reach_answers.size();
  end

endmodule

### sim/grid_monotone_reachability_core_test.sv
// Testbench top for grid_monotone_reachability_core: drives loads, queries and register
// writes under several idle patterns; gmr_reach_checker predicts and compares results.
// Depends on gmr_pkg, the core and sim/gmr_reach_checker.sv.
`timescale 1ns / 100ps

module grid_monotone_reachability_core_test;
  import gmr_pkg::*;

  localparam int ITEM_TARGET  = 1650;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT  = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    mismatch_count;
  int                    answers_owed;

  int unsigned           send_idle_pct;
  int unsigned           recv_stall_pct;
  int                    sent_items;
  int                    quiet_cycles;
  int unsigned           span_rows;
  int unsigned           span_cols;

  grid_monotone_reachability_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  gmr_reach_checker reach_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .answers_owed   (answers_owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort when nothing moves on any port for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stall the result channel at the current rate
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [GRID_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Row masks from fully free to sparse; dense ones let paths run far
  function automatic logic [GRID_W-1:0] random_row();
    case ($urandom_range(5))
      0:       return '1;
      1:       return random_word() | random_word() | random_word();
      2:       return random_word() | random_word();
      3:       return random_word();
      4:       return random_word() & random_word();
      default: return ~(64'd1 << $urandom_range(63));
    endcase
  endfunction

  // Present one request and hold it until accepted; valid stays high on return
  task automatic send_request(input logic mode, input logic [ROW_W-1:0] ridx,
                              input logic [GRID_W-1:0] bits,
                              input logic [ROW_W-1:0] sr, input logic [ROW_W-1:0] sc,
                              input logic [ROW_W-1:0] dr, input logic [ROW_W-1:0] dc);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tdata = '0;
    in_tdata[OFS_ROW_INDEX +: ROW_W] = ridx;
    in_tdata[OFS_ROW_BITS +: GRID_W] = bits;
    in_tdata[OFS_SRC_ROW +: ROW_W]   = sr;
    in_tdata[OFS_SRC_COL +: ROW_W]   = sc;
    in_tdata[OFS_DST_ROW +: ROW_W]   = dr;
    in_tdata[OFS_DST_COL +: ROW_W]   = dc;
    in_tuser  = mode;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent_items++;
  endtask

  // Loads carry random query fields, queries random row fields
  task automatic load_row(input logic [ROW_W-1:0] ridx, input logic [GRID_W-1:0] bits);
    send_request(MODE_LOAD, ridx, bits, ROW_W'($urandom), ROW_W'($urandom),
                 ROW_W'($urandom), ROW_W'($urandom));
  endtask

  task automatic ask(input logic [ROW_W-1:0] sr, input logic [ROW_W-1:0] sc,
                     input logic [ROW_W-1:0] dr, input logic [ROW_W-1:0] dc);
    send_request(MODE_QUERY, ROW_W'($urandom), random_word(), sr, sc, dr, dc);
  endtask

  // Drop valid, drain outstanding answers, then write both registers
  task automatic settle_and_configure(input logic [CFG_W-1:0] nrows,
                                      input logic [CFG_W-1:0] ncols);
    in_tvalid = 1'b0;
    while (answers_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = CFG_ROWS_IN_USE;
    cfg_wdata = nrows;
    @(negedge clk);
    cfg_index = CFG_COLS_IN_USE;
    cfg_wdata = ncols;
    @(negedge clk);
    cfg_we    = 1'b0;
    // Generate within the area in use; with a zero setting or one above 64 use the full grid
    span_rows = (nrows == 0 || nrows > 64) ? 64 : nrows;
    span_cols = (ncols == 0 || ncols > 64) ? 64 : ncols;
  endtask

  initial begin : stimulus
    int               phase;
    int unsigned      pick;
    logic [CFG_W-1:0] nrows;
    logic [CFG_W-1:0] ncols;
    logic [ROW_W-1:0] sr;
    logic [ROW_W-1:0] sc;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_ROWS_IN_USE;
    cfg_wdata      = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = MODE_LOAD;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sent_items     = 0;
    span_rows      = 64;
    span_cols      = 64;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty grid, extreme cells, reversed targets, blocked ends and cuts
    ask(0, 0, 0, 0);
    load_row(0, '1);
    ask(0, 0, 0, 63);
    ask(0, 63, 0, 0);
    load_row(63, '1);
    ask(0, 0, 63, 63);
    ask(63, 0, 63, 63);
    ask(63, 63, 0, 0);
    ask(1, 0, 0, 0);
    load_row(1, 64'h1);
    ask(0, 0, 1, 0);
    ask(0, 0, 1, 1);
    load_row(2, ~64'h1);
    ask(0, 0, 2, 5);
    ask(0, 40, 1, 40);
    load_row(63, '0);
    ask(63, 63, 63, 63);
    load_row(62, 64'hAAAA_AAAA_AAAA_AAAA);
    ask(62, 1, 62, 1);
    ask(62, 1, 62, 3);

    // Random phases: each sets registers and an idle pattern, refills rows, then mixes
    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      case (phase % 10)
        0:       begin nrows = 64;  ncols = 64;  end
        1:       begin nrows = 1;   ncols = 64;  end
        2:       begin nrows = 64;  ncols = 1;   end
        3:       begin nrows = 0;   ncols = 64;  end
        4:       begin nrows = 127; ncols = 127; end
        5:       begin nrows = 8;   ncols = 8;   end
        6:       begin nrows = 64;  ncols = 0;   end
        7:       begin nrows = 65;  ncols = 100; end
        8:       begin nrows = 3;   ncols = 64;  end
        default: begin nrows = 40;  ncols = 33;  end
      endcase
      settle_and_configure(nrows, ncols);
      case (phase % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (int r = 0; r < span_rows; r++) begin
        if ($urandom_range(9) < 7) load_row(ROW_W'(r), random_row());
      end
      repeat (100) begin
        pick = $urandom_range(99);
        if (pick < 20) begin
          if ($urandom_range(9) == 0) load_row(ROW_W'($urandom), random_row());
          else load_row(ROW_W'($urandom_range(span_rows - 1)), random_row());
        end else if (pick < 88) begin
          sr = ROW_W'($urandom_range(span_rows - 1));
          sc = ROW_W'($urandom_range(span_cols - 1));
          ask(sr, sc, ROW_W'($urandom_range(span_rows - 1, sr)),
              ROW_W'($urandom_range(span_cols - 1, sc)));
        end else begin
          ask(ROW_W'($urandom), ROW_W'($urandom), ROW_W'($urandom), ROW_W'($urandom));
        end
      end
      phase++;
    end

    // Wait for every answer, then let the block go quiet
    in_tvalid = 1'b0;
    while (answers_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && answers_owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
